### src/mfb_pkg.sv
// Package for the monochrome page-mode frame buffer engine.
// Holds operation codes, payload structs and the front-to-back command struct.
package mfb_pkg;

  localparam int DEF_PANEL_WIDTH  = 84;
  localparam int DEF_PANEL_HEIGHT = 48;
  localparam logic [7:0] BYTE_ONES = 8'hff;

  typedef enum logic [2:0] {
    OP_SET    = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_TEST   = 3'd2,
    OP_FILL   = 3'd3,
    OP_ERASE  = 3'd4,
    OP_INVERT = 3'd5,
    OP_READ   = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [6:0] x;
    logic [5:0] y;
    logic [6:0] rect_width;
    logic [5:0] rect_height;
    logic [8:0] start_index;
    logic [8:0] end_index;
  } in_item_t;

  typedef struct packed {
    logic       pixel_on;
    logic [7:0] byte_value;
  } out_item_t;

  // Command after classification and clipping (front to back).
  typedef enum logic [1:0] {
    K_NOP   = 2'd0,
    K_RECT  = 2'd1,
    K_RANGE = 2'd2,
    K_READ  = 2'd3
  } kind_t;

  // Coordinates are kept wide enough for any parameter value up to 256.
  typedef struct packed {
    kind_t      kind;
    logic       set_bits;   // rectangle fills when high, erases when low
    logic       test;       // read returns one bit instead of a byte
    logic [2:0] bit_sel;
    logic [7:0] x0;
    logic [7:0] x1;
    logic [8:0] y0;
    logic [8:0] y1;
    logic [15:0] a0;        // range start or read address
    logic [15:0] a1;        // range end
  } cmd_t;

endpackage

### src/mono_frame_buffer_raster_engine_core.sv
// Top level of the monochrome page-mode frame buffer raster engine.
// Depends on mfb_pkg, mfb_front, mfb_queue, mfb_back.
//
// Usage: push an operation beat while full is low; one result beat appears
// for every operation, in order, while empty is low, taken with pop.
// The front stage clips and classifies into a registered command; a two-entry queue
// decouples it from the back end, which owns the single-port frame memory.
// In the back end, pixel tests and byte reads take a single read; set and
// clear are a one-byte rectangle; off-panel or empty items go straight to
// the result; rectangles and inverts run a read, wait and write per touched
// byte in the read-modify-write loop through the one memory port.
// A result waiting for pop stalls the back end; the queue then fills and
// full rises. After reset the memory is swept to zero, one byte per cycle
// (PANEL_WIDTH*ceil(PANEL_HEIGHT/8) bytes, 504 by default); items are
// queued during the sweep and run after it.
module mono_frame_buffer_raster_engine_core
  import mfb_pkg::*;
#(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic f_valid, q_ready, b_valid, b_ready;
  cmd_t f_cmd, b_cmd;

  mfb_front #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_front (
    .clk, .rst, .push, .full, .in_item,
    .cmd_valid(f_valid), .cmd_ready(q_ready), .cmd(f_cmd)
  );

  mfb_queue u_queue (
    .clk, .rst, .in_valid(f_valid), .in_ready(q_ready), .in_cmd(f_cmd),
    .out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd)
  );

  mfb_back #(.PANEL_WIDTH(PANEL_WIDTH), .PANEL_HEIGHT(PANEL_HEIGHT)) u_back (
    .clk, .rst, .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
    .empty, .pop, .out_item
  );

endmodule

### src/mfb_front.sv
// Front end: accepts items, clips and classifies them into commands.
// Depends on mfb_pkg.
module mfb_front
  import mfb_pkg::*;
#(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  localparam int PAGES = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE = PANEL_WIDTH * PAGES;

  cmd_t cmd_next;
  logic [7:0]  xe;
  logic [6:0]  ye;
  logic [15:0] px_addr;
  logic        on_panel;
  logic [15:0] last;

  always_comb begin
    xe = {1'b0, in_item.x} + {1'b0, in_item.rect_width};
    ye = {1'b0, in_item.y} + {1'b0, in_item.rect_height};
    on_panel = (32'(in_item.x) < PANEL_WIDTH) && (32'(in_item.y) < PANEL_HEIGHT);
    px_addr = 16'(32'(in_item.y[5:3]) * PANEL_WIDTH + 32'(in_item.x));
    last = (32'(in_item.end_index) > STORE - 1) ? 16'(STORE - 1) : 16'(in_item.end_index);
    cmd_next = '0;
    cmd_next.bit_sel = in_item.y[2:0];
    cmd_next.x0 = 8'(in_item.x);
    cmd_next.y0 = 9'(in_item.y);
    cmd_next.x1 = (32'(xe) > PANEL_WIDTH - 1) ? 8'(PANEL_WIDTH - 1) : xe;
    cmd_next.y1 = (32'(ye) > PANEL_HEIGHT - 1) ? 9'(PANEL_HEIGHT - 1) : 9'(ye);
    cmd_next.a0 = 16'(in_item.start_index);
    cmd_next.a1 = last;
    case (op_t'(in_item.operation))
      OP_SET, OP_CLEAR: begin
        // Single pixel is a one-by-one rectangle.
        if (on_panel) cmd_next.kind = K_RECT;
        cmd_next.x1 = cmd_next.x0;
        cmd_next.y1 = cmd_next.y0;
        cmd_next.set_bits = (op_t'(in_item.operation) == OP_SET);
      end
      OP_TEST: begin
        if (on_panel) cmd_next.kind = K_READ;
        cmd_next.test = 1'b1;
        cmd_next.a0 = px_addr;
      end
      OP_FILL, OP_ERASE: begin
        if (on_panel) cmd_next.kind = K_RECT;
        cmd_next.set_bits = (op_t'(in_item.operation) == OP_FILL);
      end
      OP_INVERT: begin
        if (16'(in_item.start_index) <= last) cmd_next.kind = K_RANGE;
      end
      OP_READ: begin
        if (32'(in_item.start_index) < STORE) cmd_next.kind = K_READ;
      end
      default: cmd_next.kind = K_NOP;
    endcase
  end

  // Hold one command until the queue takes it.
  assign full = cmd_valid && !cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!full) begin
      cmd_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (!full && push) cmd <= cmd_next;
  end

endmodule

### src/mfb_queue.sv
// Two-entry command queue between front and back ends.
// Depends on mfb_pkg.
module mfb_queue
  import mfb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_cmd
);

  cmd_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_wr, do_rd;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_cmd   = slots[rd_ptr];
  assign do_wr = in_valid && in_ready;
  assign do_rd = out_valid && out_ready;

  // Advance pointers and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= in_cmd;
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");

endmodule

### src/mfb_back.sv
// Back end: owns the frame memory, walks rectangles and ranges, returns results.
// Depends on mfb_pkg.
module mfb_back
  import mfb_pkg::*;
#(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  localparam int PAGES = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE = PANEL_WIDTH * PAGES;
  localparam int AW    = $clog2(STORE);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD, S_WAIT, S_WR, S_DONE
  } state_t;

  state_t state;
  logic [7:0] mem [STORE];
  logic [7:0] rdata;
  logic [AW-1:0] addr, clr_addr;
  logic       mem_we;
  logic [7:0] wdata;
  cmd_t       cur;
  logic [7:0] col;
  logic [8:0] row;
  logic [AW-1:0] idx;
  logic [7:0] mask;
  logic       res_valid;
  out_item_t  res;
  logic [15:0] row_base;

  // Bit mask of a row inside its page: rows y0..y1 clipped to this page.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[b] = ({row[8:3], 3'(b)} >= cur.y0) && ({row[8:3], 3'(b)} <= cur.y1);
    end
  end

  always_comb begin
    row_base = 16'(32'(row[8:3]) * PANEL_WIDTH);
    addr = (state == S_CLEAR) ? clr_addr : idx;
    mem_we = (state == S_CLEAR) || (state == S_WR);
    if (state == S_CLEAR) wdata = '0;
    else if (cur.kind == K_RANGE) wdata = rdata ^ BYTE_ONES;
    else if (cur.set_bits) wdata = rdata | mask;
    else wdata = rdata & ~mask;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

  assign cmd_ready = (state == S_IDLE) && !res_valid;
  assign empty = !res_valid;
  assign out_item = res;

  // Sequencer: clear sweep, then read-modify-write per byte, or one read for reads and tests.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (pop && res_valid) res_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == STORE - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid && !res_valid) begin
            cur <= cmd;
            res <= '0;
            col <= cmd.x0;
            row <= cmd.y0;
            case (cmd.kind)
              K_RECT: begin
                idx <= AW'(32'(cmd.y0[8:3]) * PANEL_WIDTH + 32'(cmd.x0));
                state <= S_RD;
              end
              K_RANGE, K_READ: begin
                idx <= AW'(cmd.a0);
                state <= S_RD;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_RD: state <= S_WAIT;
        S_WAIT: begin
          if (cur.kind == K_READ) begin
            res.byte_value <= cur.test ? 8'd0 : rdata;
            res.pixel_on   <= cur.test ? rdata[cur.bit_sel] : 1'b0;
            state <= S_DONE;
          end else begin
            state <= S_WR;
          end
        end
        S_WR: begin
          if (cur.kind == K_RANGE) begin
            if (16'(idx) == cur.a1) begin
              state <= S_DONE;
            end else begin
              idx <= idx + 1'b1;
              state <= S_RD;
            end
          end else if (col != cur.x1) begin
            col <= col + 1'b1;
            idx <= idx + 1'b1;
            state <= S_RD;
          end else if ({row[8:3], 3'b111} >= cur.y1) begin
            state <= S_DONE;
          end else begin
            // Next page, back to the left edge.
            row <= {row[8:3] + 6'd1, 3'b000};
            col <= cur.x0;
            idx <= AW'(32'(row_base) + PANEL_WIDTH + 32'(cur.x0));
            state <= S_RD;
          end
        end
        S_DONE: begin
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state == S_WR) |-> $past(state) == S_WAIT)
    else $error("write without read");
  assert property (@(posedge clk) disable iff (rst) (state == S_DONE) |=> res_valid)
    else $error("result lost");
  assert property (@(posedge clk) disable iff (rst) res_valid |-> !cmd_ready)
    else $error("accept while result waits");

endmodule

### tb/mfb_checker.sv
// Checker for the frame buffer engine: predicts each result beat from pushed beats.
// Depends on mfb_pkg; keeps its own copy of the frame store.
module mfb_checker
  import mfb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  logic      full,
  input  in_item_t  in_item,
  input  logic      empty,
  input  logic      pop,
  input  out_item_t out_item,
  output int        errors,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = DEF_PANEL_WIDTH;
  localparam int PH = DEF_PANEL_HEIGHT;
  localparam int STORE_BYTES = PW * ((PH + 7) / 8);

  logic [7:0] shadow_frame [STORE_BYTES];
  out_item_t  expected_q [$];

  // Apply one operation to the shadow frame and return its result.
  function automatic out_item_t apply_op(in_item_t it);
    out_item_t r;
    int c1, r1, lim;
    r = '0;
    case (op_t'(it.operation))
      OP_SET, OP_CLEAR: begin
        if (it.x < PW && it.y < PH) begin
          if (it.operation == OP_SET)
            shadow_frame[(it.y / 8) * PW + it.x][it.y % 8] = 1'b1;
          else
            shadow_frame[(it.y / 8) * PW + it.x][it.y % 8] = 1'b0;
        end
      end
      OP_TEST: begin
        if (it.x < PW && it.y < PH)
          r.pixel_on = shadow_frame[(it.y / 8) * PW + it.x][it.y % 8];
      end
      OP_FILL, OP_ERASE: begin
        c1 = it.x + it.rect_width;
        r1 = it.y + it.rect_height;
        if (c1 > PW - 1) c1 = PW - 1;
        if (r1 > PH - 1) r1 = PH - 1;
        for (int row = it.y; row <= r1; row++)
          for (int col = it.x; col <= c1; col++)
            shadow_frame[(row / 8) * PW + col][row % 8] = (it.operation == OP_FILL);
      end
      OP_INVERT: begin
        lim = (it.end_index > STORE_BYTES - 1) ? STORE_BYTES - 1 : it.end_index;
        for (int i = it.start_index; i <= lim; i++)
          shadow_frame[i] = shadow_frame[i] ^ BYTE_ONES;
      end
      OP_READ: begin
        if (it.start_index < STORE_BYTES) r.byte_value = shadow_frame[it.start_index];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  assign pending = expected_q.size();

  // Predict on accepted input beats, compare on accepted result beats.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      foreach (shadow_frame[i]) shadow_frame[i] = '0;
      expected_q.delete();
      errors = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", out_item, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_item.pixel_on !== want.pixel_on)
            report_mismatch("pixel_on", out_item.pixel_on, want.pixel_on);
          if (out_item.byte_value !== want.byte_value)
            report_mismatch("byte_value", out_item.byte_value, want.byte_value);
        end
      end
      if (push && !full) expected_q.push_back(apply_op(in_item));
    end
  end
endmodule

### tb/mono_frame_buffer_raster_engine_core_tb.sv
// Testbench top: drives operation beats into the frame buffer engine and gives the verdict.
// Depends on mfb_pkg, mfb_checker and mono_frame_buffer_raster_engine_core.
module mono_frame_buffer_raster_engine_core_tb;
  import mfb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT  = 1000000;

  logic      clk = 0;
  logic      rst = 1;
  logic      push = 0;
  logic      pop = 0;
  logic      full, empty;
  in_item_t  in_item = '0;
  out_item_t out_item;
  int        errors, pending;
  int        cycles = 0;
  bit        calm = 0;

  always #5 clk = ~clk;

  mono_frame_buffer_raster_engine_core u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  mfb_checker u_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item), .errors(errors), .pending(pending)
  );

  // Stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stall bursts, none near the end.
  initial begin
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        pop <= 0;
        n = $urandom_range(1, 10);
        repeat (n) @(posedge clk);
      end else begin
        pop <= 1;
        @(posedge clk);
      end
    end
  end

  // Send one beat; hold it until accepted, with an optional gap first.
  task automatic send_op(in_item_t it);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      push <= 0;
      n = $urandom_range(1, 10);
      repeat (n) @(posedge clk);
    end
    push <= 1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  function automatic in_item_t make_op(op_t op, int x, int y, int w, int h, int s, int e);
    in_item_t it;
    it.operation = op;
    it.x = 7'(x); it.y = 6'(y); it.rect_width = 7'(w); it.rect_height = 6'(h);
    it.start_index = 9'(s); it.end_index = 9'(e);
    return it;
  endfunction

  // Mostly on-panel values, sometimes the full field range.
  function automatic in_item_t random_op();
    in_item_t it;
    it = $bits(in_item_t)'({$urandom, $urandom});
    if ($urandom_range(0, 7) != 0) begin
      it.operation = 3'($urandom_range(0, 6));
      it.x = 7'($urandom_range(0, 83));
      it.y = 6'($urandom_range(0, 47));
      it.rect_width = 7'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                                   : $urandom_range(0, 6));
      it.rect_height = 6'($urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
                                                    : $urandom_range(0, 9));
      it.start_index = 9'($urandom_range(0, 503));
      it.end_index = 9'($urandom_range(0, 3) == 0 ? $urandom_range(0, 511)
                                                  : 32'(it.start_index) + $urandom_range(0, 8));
    end
    return it;
  endfunction

  initial begin
    int tail;
    repeat (4) @(posedge clk);
    rst <= 0;
    // Directed: every operation, edges, clipping and off-panel cases.
    send_op(make_op(OP_TEST, 0, 0, 0, 0, 0, 0));
    send_op(make_op(OP_SET, 0, 0, 0, 0, 0, 0));
    send_op(make_op(OP_SET, 83, 47, 0, 0, 0, 0));
    send_op(make_op(OP_TEST, 83, 47, 0, 0, 0, 0));
    send_op(make_op(OP_SET, 127, 63, 0, 0, 0, 0));
    send_op(make_op(OP_TEST, 127, 63, 0, 0, 0, 0));
    send_op(make_op(OP_CLEAR, 84, 10, 0, 0, 0, 0));
    send_op(make_op(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    send_op(make_op(OP_READ, 0, 0, 0, 0, 503, 0));
    send_op(make_op(OP_FILL, 80, 44, 127, 63, 0, 0));
    send_op(make_op(OP_READ, 0, 0, 0, 0, 503, 0));
    send_op(make_op(OP_FILL, 100, 50, 5, 5, 0, 0));
    send_op(make_op(OP_FILL, 3, 5, 0, 0, 0, 0));
    send_op(make_op(OP_ERASE, 0, 0, 127, 63, 0, 0));
    send_op(make_op(OP_INVERT, 0, 0, 0, 0, 0, 511));
    send_op(make_op(OP_READ, 0, 0, 0, 0, 250, 0));
    send_op(make_op(OP_INVERT, 0, 0, 0, 0, 300, 200));
    send_op(make_op(OP_INVERT, 0, 0, 0, 0, 511, 511));
    send_op(make_op(OP_READ, 0, 0, 0, 0, 511, 0));
    send_op(make_op(OP_NONE, 127, 63, 127, 63, 511, 511));
    send_op(make_op(OP_READ, 0, 0, 0, 0, 0, 0));
    // Drain fully before the random part.
    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - 100) calm = 1;
      send_op(random_op());
    end
    push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    tail = 0;
    while (tail < 50) begin
      @(posedge clk);
      tail++;
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

### files.f
src/mfb_pkg.sv
src/mfb_front.sv
src/mfb_queue.sv
src/mfb_back.sv
src/mono_frame_buffer_raster_engine_core.sv
tb/mfb_checker.sv
tb/mono_frame_buffer_raster_engine_core_tb.sv
